/* hw/rtl/bfiq_pkg.sv */
// Shared types and constants for the Bloom filter insert and query unit.
`timescale 1ns / 1ps

package bfiq_pkg;

   localparam int STORE_BYTES = 65536;
   localparam int BYTE_AW     = $clog2(STORE_BYTES);
   localparam int MAX_BITS    = STORE_BYTES * 8;
   localparam int MIN_BITS    = 8;
   localparam int MAX_PROBES  = 64;
   localparam int HASH_W      = 64;
   localparam int NHASH_W     = 7;
   localparam int NBITS_W     = 20;
   localparam int COUNT_W     = 32;
   localparam int CSR_AW      = 1;
   localparam int CSR_DW      = 20;
   localparam int DIVD_W      = HASH_W + 1;
   localparam int DCNT_W      = $clog2(DIVD_W + 1);

   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_QUERY  = 1'b1
   } func_type;

   typedef enum logic [CSR_AW-1:0] {
      CSR_NUM_HASHES = 1'b0,
      CSR_NUM_BITS   = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic [NHASH_W-1:0] num_hashes;
      logic [NBITS_W-1:0] num_bits;
   } cfg_type;

   typedef struct packed {
      func_type            func;
      logic [HASH_W-1:0]   first_hash;
      logic [HASH_W-1:0]   second_hash;
   } cmd_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } eng_status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD_LOAD,
      ST_MOD_WAIT,
      ST_PREP,
      ST_PROBE_RD,
      ST_PROBE_CHK,
      ST_FINISH
   } eng_state_type;

endpackage

/* hw/rtl/bfiq_queue.sv */
// Two-entry command queue between the front end and the probe engine.
`timescale 1ns / 1ps

module bfiq_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bfiq_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output bfiq_pkg::cmd_type head_cmd
);
   import bfiq_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head_cmd  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hw/rtl/bfiq_mod_unit.sv */
// Bit-serial remainder unit: a 65-bit dividend modulo a 20-bit modulus.
`timescale 1ns / 1ps

module bfiq_mod_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bfiq_pkg::DIVD_W-1:0]  dividend,
   input  logic [bfiq_pkg::NBITS_W-1:0] modulus,
   output logic                         done,
   output logic [bfiq_pkg::NBITS_W-1:0] remainder
);
   import bfiq_pkg::*;

   logic [DIVD_W-1:0]  div_ff, div_in;
   logic [NBITS_W-1:0] rem_ff, rem_in;
   logic [DCNT_W-1:0]  cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [NBITS_W:0]   trial;

   assign done      = done_ff;
   assign remainder = rem_ff;

   always_comb begin
      trial   = {rem_ff, div_ff[DIVD_W-1]};
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         div_in  = dividend;
         rem_in  = '0;
         cnt_in  = DCNT_W'(DIVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         div_in = {div_ff[DIVD_W-2:0], 1'b0};
         // The partial remainder stays below the modulus, so one subtract suffices.
         if (trial >= {1'b0, modulus}) begin
            rem_in = NBITS_W'(trial - {1'b0, modulus});
         end else begin
            rem_in = trial[NBITS_W-1:0];
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

endmodule

/* hw/rtl/bfiq_engine.sv */
// Probe engine: clears the bit store, walks the probes and registers each result.
`timescale 1ns / 1ps

module bfiq_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  bfiq_pkg::cfg_type             cfg,
   input  logic                          cmd_valid,
   input  bfiq_pkg::cmd_type             cmd,
   output bfiq_pkg::eng_status_type      status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_maybe_present,
   output logic [bfiq_pkg::COUNT_W-1:0]  rsp_items_added
);
   import bfiq_pkg::*;

   eng_state_type state_ff, state_in;

   logic [7:0]          mem [STORE_BYTES];
   logic [7:0]          rdata_ff;
   logic                mem_we;
   logic [BYTE_AW-1:0]  mem_waddr;
   logic [7:0]          mem_wdata;
   logic [BYTE_AW-1:0]  mem_raddr;
   logic [BYTE_AW-1:0]  mem_raddr_hold;

   logic [BYTE_AW-1:0]  clr_ff, clr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                present_out_ff, present_out_in;
   logic [COUNT_W-1:0]  items_out_ff, items_out_in;

   func_type            func_ff, func_in;
   logic [HASH_W-1:0]   h1_ff, h1_in;
   logic [HASH_W-1:0]   h2_ff, h2_in;
   logic [HASH_W-1:0]   x_ff, x_in;
   logic [NBITS_W-1:0]  r_ff, r_in;
   logic [NBITS_W-1:0]  d0_ff, d0_in;
   logic [NBITS_W-1:0]  d1_ff, d1_in;
   logic [NBITS_W-1:0]  c_ff, c_in;
   logic [1:0]          sel_ff, sel_in;
   logic [NHASH_W-1:0]  left_ff, left_in;
   logic [2:0]          bpos_ff, bpos_in;
   logic                present_ff, present_in;

   logic [NBITS_W-1:0]  modulus;
   logic [NHASH_W-1:0]  probes;
   logic                mod_start, mod_done;
   logic [DIVD_W-1:0]   mod_dividend;
   logic [NBITS_W-1:0]  mod_rem;
   logic [HASH_W:0]     x_sum;
   logic [NBITS_W:0]    r_sum;
   logic [7:0]          bit_mask;
   logic                out_free;

   bfiq_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .modulus   (modulus),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      if (cfg.num_bits < NBITS_W'(MIN_BITS)) begin
         modulus = NBITS_W'(MIN_BITS);
      end else if (cfg.num_bits > NBITS_W'(MAX_BITS)) begin
         modulus = NBITS_W'(MAX_BITS);
      end else begin
         modulus = cfg.num_bits;
      end
      probes = (cfg.num_hashes > NHASH_W'(MAX_PROBES)) ? NHASH_W'(MAX_PROBES)
                                                        : cfg.num_hashes;
   end

   assign out_free          = !rsp_valid_ff || rsp_ready;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_maybe_present = present_out_ff;
   assign rsp_items_added   = items_out_ff;
   assign bit_mask          = 8'(1) << bpos_ff;
   assign x_sum             = {1'b0, x_ff} + {1'b0, h2_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == {BYTE_AW{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               state_in = ST_MOD_LOAD;
            end
         end
         ST_MOD_LOAD: state_in = ST_MOD_WAIT;
         ST_MOD_WAIT: begin
            if (mod_done) begin
               state_in = (sel_ff == 2'd2) ? ST_PREP : ST_MOD_LOAD;
            end
         end
         ST_PREP: state_in = (probes == '0) ? ST_FINISH : ST_PROBE_RD;
         ST_PROBE_RD: state_in = ST_PROBE_CHK;
         ST_PROBE_CHK: begin
            if ((func_ff == FUNC_QUERY && (rdata_ff & bit_mask) == 8'd0)
                || left_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_PROBE_RD;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      clr_in         = clr_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      present_out_in = present_out_ff;
      items_out_in   = items_out_ff;
      func_in        = func_ff;
      h1_in          = h1_ff;
      h2_in          = h2_ff;
      x_in           = x_ff;
      r_in           = r_ff;
      d0_in          = d0_ff;
      d1_in          = d1_ff;
      c_in           = c_ff;
      sel_in         = sel_ff;
      left_in        = left_ff;
      bpos_in        = bpos_ff;
      present_in     = present_ff;
      mod_start      = 1'b0;
      mod_dividend   = '0;
      mem_we         = 1'b0;
      mem_waddr      = r_ff[BYTE_AW+2:3];
      mem_wdata      = rdata_ff | bit_mask;
      mem_raddr      = r_ff[BYTE_AW+2:3];
      r_sum          = '0;
      status.pop     = 1'b0;
      status.clearing = (state_ff == ST_CLEAR);
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = 8'd0;
            clr_in    = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               status.pop = 1'b1;
               func_in    = cmd.func;
               h1_in      = cmd.first_hash;
               h2_in      = cmd.second_hash;
               sel_in     = 2'd0;
            end
         end
         ST_MOD_LOAD: begin
            mod_start = 1'b1;
            priority case (sel_ff)
               2'd0:    mod_dividend = {1'b0, h1_ff};
               2'd1:    mod_dividend = {1'b0, h2_ff};
               default: mod_dividend = {1'b1, {HASH_W{1'b0}}};
            endcase
         end
         ST_MOD_WAIT: begin
            if (mod_done) begin
               priority case (sel_ff)
                  2'd0:    r_in  = mod_rem;
                  2'd1:    d0_in = mod_rem;
                  default: c_in  = mod_rem;
               endcase
               sel_in = sel_ff + 1'b1;
            end
         end
         ST_PREP: begin
            // Step used when the running 64-bit index wraps: stride minus 2^64, mod m.
            if (d0_ff >= c_ff) begin
               d1_in = d0_ff - c_ff;
            end else begin
               d1_in = NBITS_W'({1'b0, d0_ff} + {1'b0, modulus} - {1'b0, c_ff});
            end
            x_in       = h1_ff;
            left_in    = probes;
            present_in = 1'b1;
         end
         ST_PROBE_RD: begin
            bpos_in = r_ff[2:0];
            x_in    = x_sum[HASH_W-1:0];
            r_sum   = {1'b0, r_ff} + {1'b0, (x_sum[HASH_W] ? d1_ff : d0_ff)};
            if (r_sum >= {1'b0, modulus}) begin
               r_in = NBITS_W'(r_sum - {1'b0, modulus});
            end else begin
               r_in = r_sum[NBITS_W-1:0];
            end
            left_in = left_ff - 1'b1;
         end
         ST_PROBE_CHK: begin
            // The write address must be the byte just read, not the advanced index.
            mem_waddr = mem_raddr_hold;
            if (func_ff == FUNC_QUERY) begin
               if ((rdata_ff & bit_mask) == 8'd0) begin
                  present_in = 1'b0;
               end
            end else begin
               mem_we = 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (func_ff == FUNC_INSERT) begin
                  present_out_in = 1'b1;
                  if (count_ff != {COUNT_W{1'b1}}) begin
                     count_in     = count_ff + 1'b1;
                     items_out_in = count_ff + 1'b1;
                  end else begin
                     items_out_in = count_ff;
                  end
               end else begin
                  present_out_in = present_ff;
                  items_out_in   = count_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         sel_ff       <= 2'd0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         sel_ff       <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      present_out_ff <= present_out_in;
      items_out_ff   <= items_out_in;
      func_ff        <= func_in;
      h1_ff          <= h1_in;
      h2_ff          <= h2_in;
      x_ff           <= x_in;
      r_ff           <= r_in;
      d0_ff          <= d0_in;
      d1_ff          <= d1_in;
      c_ff           <= c_in;
      left_ff        <= left_in;
      bpos_ff        <= bpos_in;
      present_ff     <= present_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff       <= mem[mem_raddr];
      mem_raddr_hold <= mem_raddr;
   end

endmodule

/* hw/rtl/bloom_filter_insert_query_unit.sv */
// Top level: configuration registers, request front end, queue and probe engine.
`timescale 1ns / 1ps

// Bloom filter with double hashing over a 524288-bit store.
// Requests arrive on the req_ channel (func, first_hash, second_hash); each
// transaction yields exactly one response on the rsp_ channel carrying
// rsp_maybe_present and the saturating insert count rsp_items_added.
// Accepted requests wait in a two-entry queue, so the front end keeps taking
// transactions while the engine works and while a response is held.
// The engine handles one request at a time: three remainder runs on a
// bit-serial unit (base, stride and 2^64 modulo num_bits), then a read state
// and a check state per probe on the byte memory; a query stops at the
// first clear bit.
// After reset the engine clears the 65536-byte store one byte a cycle, and
// req_ready stays low until that pass is over; configuration writes on the
// csr_ port are taken at any time. num_hashes resets to 7, num_bits to 524288.
// While rsp_ready is low the response is held, the engine stalls before issuing
// its next one, and the front end stops once the queue is full.
module bloom_filter_insert_query_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [bfiq_pkg::CSR_AW-1:0]   csr_index,
   input  logic [bfiq_pkg::CSR_DW-1:0]   csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [bfiq_pkg::HASH_W-1:0]   req_first_hash,
   input  logic [bfiq_pkg::HASH_W-1:0]   req_second_hash,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_maybe_present,
   output logic [bfiq_pkg::COUNT_W-1:0]  rsp_items_added
);
   import bfiq_pkg::*;

   cfg_type        cfg_ff, cfg_in;
   cmd_type        req_cmd, head_cmd;
   eng_status_type eng_status;
   logic           q_full, q_not_empty, q_push;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_idx_type'(csr_index))
            CSR_NUM_HASHES: cfg_in.num_hashes = csr_write_data[NHASH_W-1:0];
            CSR_NUM_BITS:   cfg_in.num_bits   = csr_write_data[NBITS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_hashes <= NHASH_W'(7);
         cfg_ff.num_bits   <= NBITS_W'(MAX_BITS);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = !q_full && !eng_status.clearing;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      req_cmd.func        = func_type'(req_func);
      req_cmd.first_hash  = req_first_hash;
      req_cmd.second_hash = req_second_hash;
   end

   bfiq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (req_cmd),
      .pop       (eng_status.pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   bfiq_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .cmd_valid         (q_not_empty),
      .cmd               (head_cmd),
      .status            (eng_status),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_maybe_present (rsp_maybe_present),
      .rsp_items_added   (rsp_items_added)
   );

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      eng_status.pop |-> q_not_empty)
      else $error("engine took a command from an empty queue");

   a_no_accept_clearing: assert property (@(posedge clock) disable iff (reset)
      eng_status.clearing |-> !q_push && !rsp_valid)
      else $error("transaction moved during the clearing pass");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(rsp_valid) && !$past(reset)
         |-> rsp_items_added >= $past(rsp_items_added))
      else $error("insert count went backwards");

endmodule
